// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the basis unit design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold on a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// ante implies cons on the same edge
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: design/slbe_pkg.sv
// ----------------------------------------------------------------------------
// slbe_pkg
// Shared types, constants and coefficient tables for the Legendre basis unit.
// ----------------------------------------------------------------------------
package slbe_pkg;

	localparam int MAX_ORDER  = 15;
	localparam int TAB_N      = 15;
	localparam int COEF_DEPTH = TAB_N * TAB_N;

	localparam logic [63:0] DBL_ONE  = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] DBL_HALF = 64'h3FE0_0000_0000_0000;
	localparam logic [63:0] DBL_DNAN = 64'hFFF8_0000_0000_0000;

	typedef enum logic {
		FOP_ADD = 1'b0,
		FOP_MUL = 1'b1
	} fop_t;

	typedef struct packed {
		logic        start;
		fop_t        op;
		logic [63:0] a;
		logic [63:0] b;
	} fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} fpu_rsp_t;

	typedef logic [63:0] coef_tab_t  [0:COEF_DEPTH-1];
	typedef logic [63:0] scale_tab_t [0:TAB_N-1];

	// exact integer (below 2^53, nonzero) to double
	function automatic logic [63:0] int_to_dbl(input longint unsigned v);
		int          msb;
		logic [63:0] sh;
		msb = 0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) msb = i;
		end
		sh = v << (52 - msb);
		return {1'b0, 11'(1023 + msb), sh[51:0]};
	endfunction

	function automatic longint unsigned binom(input int n, input int k);
		longint unsigned row [0:2*TAB_N];
		for (int j = 0; j <= 2*TAB_N; j++) row[j] = 0;
		row[0] = 1;
		for (int i = 1; i <= n; i++) begin
			for (int j = i; j > 0; j--) row[j] = row[j] + row[j-1];
		end
		return row[k];
	endfunction

	// signed coefficients (-1)^(n+k) C(n,k) C(n+k,k), row n at n*TAB_N
	function automatic coef_tab_t build_coef();
		coef_tab_t       t;
		longint unsigned mag;
		logic [63:0]     d;
		for (int i = 0; i < COEF_DEPTH; i++) t[i] = '0;
		for (int n = 0; n < TAB_N; n++) begin
			for (int k = 0; k <= n; k++) begin
				mag = binom(n, k) * binom(n + k, k);
				d = int_to_dbl(mag);
				t[n*TAB_N + k] = {1'(((n + k) & 1) != 0), d[62:0]};
			end
		end
		return t;
	endfunction

	// s_n = (2n+1) C(2n,n)
	function automatic scale_tab_t build_scale();
		scale_tab_t t;
		for (int n = 0; n < TAB_N; n++) begin
			t[n] = int_to_dbl(longint'(2*n + 1) * binom(2*n, n));
		end
		return t;
	endfunction

	localparam coef_tab_t  COEF_TAB  = build_coef();
	localparam scale_tab_t SCALE_TAB = build_scale();

endpackage

// File: design/slbe_fpu.sv
// ----------------------------------------------------------------------------
// slbe_fpu
// Multi-cycle IEEE double add / multiply, round to nearest even.
// ----------------------------------------------------------------------------
module slbe_fpu
	import slbe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  fpu_req_t req,
	output fpu_rsp_t rsp
);

	typedef enum logic [3:0] {
		F_IDLE  = 4'b0001,
		F_MULT  = 4'b0010,
		F_ALIGN = 4'b0100,
		F_NORM  = 4'b1000
	} fstate_t;

	fstate_t            state_q;
	logic               done_q;
	logic [63:0]        res_q;
	logic [52:0]        ma_q, mb_q;
	logic [10:0]        diff_q;
	logic               sub_q, s_q, zsign_q;
	logic [108:0]       m_q;
	logic signed [12:0] x_q;
	logic [1:0]         cnt_q;

	// operand decode
	logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_big;
	logic [10:0] ea, eb, ea_n, eb_n;
	logic [52:0] ma, mb;
	logic        spec;
	logic [63:0] spec_res;

	always_comb begin
		sa     = req.a[63];
		sb     = req.b[63];
		ea     = req.a[62:52];
		eb     = req.b[62:52];
		a_nan  = (ea == 11'h7FF) && (req.a[51:0] != '0);
		b_nan  = (eb == 11'h7FF) && (req.b[51:0] != '0);
		a_inf  = (ea == 11'h7FF) && (req.a[51:0] == '0);
		b_inf  = (eb == 11'h7FF) && (req.b[51:0] == '0);
		a_zero = (req.a[62:0] == '0);
		b_zero = (req.b[62:0] == '0);
		ea_n   = (ea == '0) ? 11'd1 : ea;
		eb_n   = (eb == '0) ? 11'd1 : eb;
		ma     = {ea != '0, req.a[51:0]};
		mb     = {eb != '0, req.b[51:0]};
		a_big  = (req.a[62:0] >= req.b[62:0]);
		spec     = 1'b1;
		spec_res = DBL_DNAN;
		if (a_nan) begin
			spec_res = req.a | 64'h0008_0000_0000_0000;
		end else if (b_nan) begin
			spec_res = req.b | 64'h0008_0000_0000_0000;
		end else if (req.op == FOP_MUL) begin
			if ((a_inf && b_zero) || (b_inf && a_zero)) spec_res = DBL_DNAN;
			else if (a_inf || b_inf) spec_res = {sa ^ sb, 11'h7FF, 52'b0};
			else spec = 1'b0;
		end else begin
			if (a_inf && b_inf && (sa != sb)) spec_res = DBL_DNAN;
			else if (a_inf) spec_res = req.a;
			else if (b_inf) spec_res = req.b;
			else spec = 1'b0;
		end
	end

	// multiplier pass: 53 x 14 partial product
	logic [55:0]  mb_ext;
	logic [13:0]  chunk;
	logic [66:0]  pprod;
	logic [108:0] psum;

	always_comb begin
		mb_ext = {3'b0, mb_q};
		chunk  = mb_ext[cnt_q*14 +: 14];
		pprod  = ma_q * chunk;
		psum   = m_q + ({42'b0, pprod} << (cnt_q * 14));
	end

	// alignment and sum
	logic [107:0] wide_s, sh_s, mask_s, small_v, big_v;
	logic         st_s;
	logic [108:0] asum;

	always_comb begin
		wide_s = {mb_q, 55'b0};
		big_v  = {ma_q, 55'b0};
		mask_s = (108'b1 << diff_q) - 108'b1;
		if (diff_q >= 11'd108) begin
			sh_s = '0;
			st_s = |mb_q;
		end else begin
			sh_s = wide_s >> diff_q;
			st_s = |(wide_s & mask_s);
		end
		small_v = sh_s | {107'b0, st_s};
		asum = sub_q ? ({1'b0, big_v} - {1'b0, small_v})
		             : ({1'b0, big_v} + {1'b0, small_v});
	end

	// rounding
	logic [52:0]        mant, mant_f;
	logic               rnd_up;
	logic [53:0]        mant_r;
	logic signed [12:0] x_f;
	logic [10:0]        exp_f;
	logic [63:0]        rnd_res;

	always_comb begin
		mant   = m_q[107:55];
		rnd_up = m_q[54] && ((|m_q[53:0]) || mant[0]);
		mant_r = {1'b0, mant} + {53'b0, rnd_up};
		if (mant_r[53]) begin
			mant_f = mant_r[53:1];
			x_f    = x_q + 13'sd1;
		end else begin
			mant_f = mant_r[52:0];
			x_f    = x_q;
		end
		exp_f = mant_f[52] ? x_f[10:0] : 11'd0;
		if (m_q == '0) rnd_res = {zsign_q, 63'b0};
		else if (x_f >= 13'sd2047) rnd_res = {s_q, 11'h7FF, 52'b0};
		else rnd_res = {s_q, exp_f, mant_f[51:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				F_IDLE: begin
					if (req.start) begin
						if (spec) begin
							res_q  <= spec_res;
							done_q <= 1'b1;
						end else if (req.op == FOP_MUL) begin
							ma_q    <= ma;
							mb_q    <= mb;
							s_q     <= sa ^ sb;
							zsign_q <= sa ^ sb;
							x_q     <= $signed({2'b0, ea_n}) + $signed({2'b0, eb_n})
							           - 13'sd1022;
							m_q     <= '0;
							cnt_q   <= '0;
							state_q <= F_MULT;
						end else begin
							ma_q    <= a_big ? ma : mb;
							mb_q    <= a_big ? mb : ma;
							diff_q  <= a_big ? (ea_n - eb_n) : (eb_n - ea_n);
							x_q     <= $signed({2'b0, (a_big ? ea_n : eb_n)});
							s_q     <= a_big ? sa : sb;
							sub_q   <= sa ^ sb;
							zsign_q <= sa & sb;
							state_q <= F_ALIGN;
						end
					end
				end
				F_MULT: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						m_q     <= psum << 2;
						state_q <= F_NORM;
					end else begin
						m_q <= psum;
					end
				end
				F_ALIGN: begin
					m_q     <= asum;
					state_q <= F_NORM;
				end
				F_NORM: begin
					if (m_q[108]) begin
						m_q <= {1'b0, m_q[108:2], m_q[1] | m_q[0]};
						x_q <= x_q + 13'sd1;
					end else if (x_q < -13'sd110) begin
						m_q <= {108'b0, |m_q};
						x_q <= 13'sd1;
					end else if (x_q < 13'sd1) begin
						m_q <= {1'b0, m_q[108:2], m_q[1] | m_q[0]};
						x_q <= x_q + 13'sd1;
					end else if (!m_q[107] && (x_q > 13'sd1) && (m_q != '0)) begin
						m_q <= {m_q[107:0], 1'b0};
						x_q <= x_q - 13'sd1;
					end else begin
						res_q   <= rnd_res;
						done_q  <= 1'b1;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

// File: design/scaled_legendre_basis_eval_unit.sv
// Sequence: a result of degree n takes n multiply-add pairs and one scaling multiply
//   on the shared FPU; mapping the coordinate costs one add and one multiply first.
// FPU: partial-product passes (mul) or alignment (add), then bit-wise normalize, round.
// Throughput: one item at a time, input not ready until its last result leaves.
// Reset: arst_n clears the sequencer, FPU state and output valid asynchronously.
// ----------------------------------------------------------------------------
// scaled_legendre_basis_eval_unit
// Evaluates scaled shifted Legendre polynomials at x=(1+qsi)/2 by Horner.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scaled_legendre_basis_eval_unit
	import slbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [63:0] coordinate_bits, [68:64] poly_order, [75:69] function_count, rest 0
	input  logic [79:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [5:0] func_position, [69:6] value_bits, [71:70] zero
	output logic [71:0] m_axis_tdata,
	output logic        m_axis_tlast,   // is_last
	output logic        m_axis_tuser    // order_error
);

	// one-hot sequencer states
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SUM   = 7'b0000010,  // 1 + qsi
		ST_HALF  = 7'b0000100,  // * 0.5
		ST_MUL   = 7'b0001000,  // acc * x
		ST_ADD   = 7'b0010000,  // acc + coef
		ST_SCALE = 7'b0100000,  // s_n * acc
		ST_OUT   = 7'b1000000   // result waits in output register
	} state_t;

	state_t      state_q;
	logic        issued_q;
	logic [63:0] q_q, x_q, acc_q;
	logic [3:0]  p_q, n_q, k_q;
	logic [5:0]  pos_q;

	logic [5:0]  out_pos_q;
	logic [63:0] out_val_q;
	logic        out_last_q, out_err_q;

	fpu_req_t fpu_req;
	fpu_rsp_t fpu_rsp;

	// input fields
	logic [63:0] in_coord;
	logic [4:0]  in_order;
	logic [6:0]  in_count;
	logic        in_bad;

	assign in_coord = s_axis_tdata[63:0];
	assign in_order = s_axis_tdata[68:64];
	assign in_count = s_axis_tdata[75:69];
	assign in_bad   = (in_order == 5'd0) || (in_order > 5'(MAX_ORDER))
	                  || (in_count < {2'b0, in_order});

	assign s_axis_tready = (state_q == ST_IDLE);

	// table reads: current coefficient and diagonal of the next polynomial
	logic [3:0]  nn;
	logic [7:0]  cidx;
	logic [63:0] coef_cur, coef_diag;

	always_comb begin
		nn        = (state_q == ST_HALF) ? (p_q - 4'd1) : (n_q - 4'd1);
		cidx      = ({4'b0, n_q} << 4) - {4'b0, n_q} + {4'b0, k_q};
		coef_cur  = COEF_TAB[cidx];
		coef_diag = COEF_TAB[{nn, 4'b0}];
	end

	// FPU request per state; start once per step
	always_comb begin
		fpu_req.start = 1'b0;
		fpu_req.op    = FOP_ADD;
		fpu_req.a     = acc_q;
		fpu_req.b     = x_q;
		case (state_q)
			ST_SUM: begin
				fpu_req.start = !issued_q;
				fpu_req.a     = DBL_ONE;
				fpu_req.b     = q_q;
			end
			ST_HALF: begin
				fpu_req.start = !issued_q;
				fpu_req.op    = FOP_MUL;
				fpu_req.a     = x_q;
				fpu_req.b     = DBL_HALF;
			end
			ST_MUL: begin
				fpu_req.start = !issued_q;
				fpu_req.op    = FOP_MUL;
			end
			ST_ADD: begin
				fpu_req.start = !issued_q;
				fpu_req.b     = coef_cur;
			end
			ST_SCALE: begin
				fpu_req.start = !issued_q;
				fpu_req.op    = FOP_MUL;
				fpu_req.a     = SCALE_TAB[n_q];
				fpu_req.b     = acc_q;
			end
			default: fpu_req.start = 1'b0;
		endcase
	end

	slbe_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.rsp    (fpu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
		end else begin
			if (fpu_rsp.done) issued_q <= 1'b0;
			else if (fpu_req.start) issued_q <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						q_q   <= in_coord;
						p_q   <= in_order[3:0];
						pos_q <= in_count[5:0] - 6'd1;
						if (in_bad) begin
							out_pos_q  <= '0;
							out_val_q  <= '0;
							out_last_q <= 1'b1;
							out_err_q  <= 1'b1;
							state_q    <= ST_OUT;
						end else begin
							state_q <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					if (fpu_rsp.done) begin
						x_q     <= fpu_rsp.res;
						state_q <= ST_HALF;
					end
				end
				ST_HALF: begin
					if (fpu_rsp.done) begin
						x_q     <= fpu_rsp.res;
						n_q     <= nn;
						k_q     <= nn;
						acc_q   <= coef_diag;
						state_q <= (nn == 4'd0) ? ST_SCALE : ST_MUL;
					end
				end
				ST_MUL: begin
					if (fpu_rsp.done) begin
						acc_q   <= fpu_rsp.res;
						k_q     <= k_q - 4'd1;
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (fpu_rsp.done) begin
						acc_q   <= fpu_rsp.res;
						state_q <= (k_q == 4'd0) ? ST_SCALE : ST_MUL;
					end
				end
				ST_SCALE: begin
					if (fpu_rsp.done) begin
						out_pos_q  <= pos_q;
						out_val_q  <= fpu_rsp.res;
						out_last_q <= (n_q == 4'd0);
						out_err_q  <= 1'b0;
						state_q    <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						if (out_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							// next lower order, next lower position
							pos_q   <= pos_q - 6'd1;
							n_q     <= nn;
							k_q     <= nn;
							acc_q   <= coef_diag;
							state_q <= (nn == 4'd0) ? ST_SCALE : ST_MUL;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {2'b0, out_val_q, out_pos_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_err_q;

	// input is never taken while a result is pending
	`ASSERT_NEVER(a_no_overlap, s_axis_tready && m_axis_tvalid, "input ready with result pending")
	// an error item produces exactly one, final result
	`ASSERT_IMPL(a_err_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "error result not last")
	// FPU answers only a step that was issued
	`ASSERT_IMPL(a_fpu_done, fpu_rsp.done, issued_q, "FPU done without request")
	// no new FPU start while one is in flight
	`ASSERT_NEVER(a_fpu_start, fpu_req.start && issued_q, "FPU start while busy")

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream test of the scaled Legendre basis unit. A double-precision Horner
// predictor queues the results of each accepted item; every result read from
// the output stream is checked field by field against the oldest one queued.
// ----------------------------------------------------------------------------
module tb;
	import slbe_pkg::*;

	typedef struct {
		logic [5:0]  pos;
		logic [63:0] val;
		logic        last;
		logic        err;
	} basis_res_t;

	// Queue of predicted basis values, one entry per expected output item
	class basis_scoreboard;
		basis_res_t pending[$];
		int         errors;

		// scale_n * Pt_n(x) by Horner, coefficients from running binomials
		function real basis_value(int n, real x);
			longint unsigned ca, cb;
			real             coef[0:MAX_ORDER-1];
			real             acc;
			real             mag;
			longint unsigned cbin;
			ca = 1;
			cb = 1;
			for (int k = 0; k <= n; k++) begin
				mag = real'(ca * cb);
				coef[k] = ((n + k) % 2 != 0) ? -mag : mag;
				if (k < n) begin
					ca = ca * longint'(n - k) / longint'(k + 1);
					cb = cb * longint'(n + k + 1) / longint'(k + 1);
				end
			end
			acc = coef[n];
			for (int k = n - 1; k >= 0; k--) acc = acc * x + coef[k];
			// (2n+1) * C(2n,n)
			cbin = 1;
			for (int k = 0; k < n; k++) cbin = cbin * longint'(2*n - k) / longint'(k + 1);
			return real'(longint'(2*n + 1) * cbin) * acc;
		endfunction

		function void note_item(logic [63:0] coord, logic [4:0] ord, logic [6:0] cnt);
			basis_res_t r;
			real        x;
			if (ord == 0 || ord > MAX_ORDER || cnt < ord) begin
				r.pos = '0;
				r.val = '0;
				r.last = 1'b1;
				r.err = 1'b1;
				pending.push_back(r);
			end else begin
				x = (1.0 + $bitstoreal(coord)) / 2.0;
				for (int j = 0; j < ord; j++) begin
					r.pos = 6'(cnt - 1 - j);
					r.val = $realtobits(basis_value(ord - j - 1, x));
					r.last = (ord - j == 1);
					r.err = 1'b0;
					pending.push_back(r);
				end
			end
		endfunction

		function void check_result(logic [5:0] pos, logic [63:0] val, logic last, logic err);
			basis_res_t e;
			bit         nan_e, nan_a;
			if (pending.size() == 0) begin
				$display("%0t: unexpected item pos=%0d val=%h last=%b err=%b",
					$time, pos, val, last, err);
				errors++;
				return;
			end
			e = pending.pop_front();
			// NaN payloads are not defined, any NaN matches a NaN
			nan_e = (e.val[62:52] == 11'h7FF) && (e.val[51:0] != 0);
			nan_a = (val[62:52] == 11'h7FF) && (val[51:0] != 0);
			if (pos !== e.pos) begin
				$display("%0t: func_position expected %0d actual %0d", $time, e.pos, pos);
				errors++;
			end
			if (!(nan_e && nan_a) && val !== e.val) begin
				$display("%0t: value_bits expected %h actual %h", $time, e.val, val);
				errors++;
			end
			if (last !== e.last) begin
				$display("%0t: is_last expected %b actual %b", $time, e.last, last);
				errors++;
			end
			if (err !== e.err) begin
				$display("%0t: order_error expected %b actual %b", $time, e.err, err);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;

	basis_scoreboard sb = new();
	int  items_in;
	bit  quiet;
	bit  long_hold_done;
	int  rx_hold;

	scaled_legendre_basis_eval_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Receiver: check on handshake, then pick ready for the next edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata[5:0], m_axis_tdata[69:6], m_axis_tlast,
					m_axis_tuser);
			if (!long_hold_done && items_in == 40) begin
				// long back-pressure so the unit fills and stalls its input
				long_hold_done = 1;
				rx_hold = 3000;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				rx_hold = $urandom_range(1, 13) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send_item(logic [63:0] coord, logic [4:0] ord, logic [6:0] cnt);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, cnt, ord, coord};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(coord, ord, cnt);
		items_in++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_coord();
		real u;
		case ($urandom_range(0, 9))
			0: return {$urandom, $urandom};
			1: begin
				case ($urandom_range(0, 5))
					0: return 64'hBFF0_0000_0000_0000;
					1: return 64'h3FF0_0000_0000_0000;
					2: return 64'h0000_0000_0000_0000;
					3: return 64'h8000_0000_0000_0000;
					4: return 64'h7FF0_0000_0000_0000;
					default: return {1'b1, 11'h7FF, 20'($urandom), $urandom};
				endcase
			end
			default: begin
				u = real'($urandom) / 4294967296.0 + real'($urandom) / 18446744073709551616.0;
				return $realtobits(2.0 * u - 1.0);
			end
		endcase
	endfunction

	initial begin
		logic [4:0] ord;
		logic [6:0] cnt;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		items_in = 0;
		quiet = 0;
		long_hold_done = 0;
		rx_hold = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// endpoints, zeros, midpoint, non-finite coordinates
		send_item(64'hBFF0_0000_0000_0000, 5'd15, 7'd15);
		send_item(64'h3FF0_0000_0000_0000, 5'd15, 7'd64);
		send_item(64'h0000_0000_0000_0000, 5'd3, 7'd3);
		send_item(64'h8000_0000_0000_0000, 5'd1, 7'd1);
		send_item(64'h3FE0_0000_0000_0000, 5'd7, 7'd127);
		send_item(64'h7FF0_0000_0000_0000, 5'd2, 7'd10);
		send_item(64'hFFF0_0000_0000_0000, 5'd2, 7'd10);
		send_item(64'h7FF8_0000_0000_0001, 5'd4, 7'd9);
		send_item(64'hFFFF_FFFF_FFFF_FFFF, 5'd1, 7'd100);
		send_item(64'h4010_0000_0000_0000, 5'd5, 7'd70);
		// bad order, small count
		send_item(64'h3FE0_0000_0000_0000, 5'd0, 7'd5);
		send_item(64'h3FE0_0000_0000_0000, 5'd16, 7'd64);
		send_item(64'h3FE0_0000_0000_0000, 5'd31, 7'd127);
		send_item(64'h3FE0_0000_0000_0000, 5'd15, 7'd14);
		send_item(64'h3FE0_0000_0000_0000, 5'd1, 7'd0);
		send_item(64'h3FE0_0000_0000_0000, 5'd8, 7'd65);
		drain();

		for (int i = 0; i < 460; i++) begin
			if (i == 200) drain();
			if (i == 400) quiet = 1;
			if ($urandom_range(0, 9) < 8) ord = 5'($urandom_range(1, MAX_ORDER));
			else ord = 5'($urandom_range(0, 31));
			if ($urandom_range(0, 4) != 0) cnt = 7'($urandom_range(ord, 127));
			else cnt = 7'($urandom_range(0, 127));
			send_item(rand_coord(), ord, cnt);
		end
		drain();
		repeat (200) @(posedge clk);

		while (sb.pending.size() != 0) begin
			void'(sb.pending.pop_front());
			$display("%0t: expected item never arrived", $time);
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#30000000;
		$display("tb failed");
		$finish;
	end
endmodule
